// ===== design/pld_pkg.sv =====
// Shared types, constants and elaboration-time helper functions for the power-law
// midtone dodge block. This package depends on nothing else.
package pld_pkg;

   localparam int unsigned FRAC_BITS = 24;
   localparam int unsigned EXP_BITS = 15;
   localparam logic [15:0] EXP_ONE = 16'd8192;
   // Register stages through one colour lane: log2 25, difference 1, divider 30, power 25.
   localparam int unsigned LANE_LAT = 81;

   typedef struct packed {
      logic [15:0] red_in;
      logic [15:0] green_in;
      logic [15:0] blue_in;
      logic [15:0] alpha_in;
      logic        last_pixel;
   } pix_in_type;

   typedef struct packed {
      logic [15:0] red_out;
      logic [15:0] green_out;
      logic [15:0] blue_out;
      logic [15:0] alpha_out;
      logic        last_pixel_out;
   } pix_out_type;

   function automatic longint unsigned isqrt64(input longint unsigned v_arg);
      longint unsigned v;
      longint unsigned r;
      longint unsigned b;
      v = v_arg;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Returns 2^(-2^-k) in Q32 by repeated square roots from one half.
   function automatic logic [31:0] pow_const(input int k);
      longint unsigned c;
      c = 64'd1 << 31;
      for (int i = 1; i <= k; i++) c = isqrt64(c << 32);
      return c[31:0];
   endfunction

   // Same squaring scheme as the hardware log2 unit, used for the full-scale constant.
   function automatic logic [27:0] log2_q24(input logic [15:0] v);
      longint unsigned m;
      logic [3:0] n;
      logic [23:0] f;
      n = '0;
      f = '0;
      for (int i = 0; i < 16; i++) if (v[i]) n = 4'(i);
      m = 64'(v) << (31 - n);
      for (int i = 23; i >= 0; i--) begin
         m = (m * m) >> 31;
         if (m >= (64'd1 << 32)) begin
            f[i] = 1'b1;
            m = m >> 1;
         end
      end
      return {n, f};
   endfunction

endpackage

// ===== design/pld_log2.sv =====
// Pipelined base-2 logarithm of a 16-bit sample, unsigned Q.24 result, one fraction
// bit per stage by repeated squaring. Depends on pld_pkg.
module pld_log2 import pld_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [15:0] v,
   output logic [27:0] lx
);

   logic [3:0]  lead;
   logic [31:0] norm;
   logic [31:0] m_ff [0:24];
   logic [23:0] f_ff [0:24];
   logic [3:0]  n_ff [0:24];

   always_comb begin
      lead = '0;
      for (int i = 0; i < 16; i++) if (v[i]) lead = 4'(i);
      norm = 32'(v) << (5'd31 - {1'b0, lead});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0] <= norm;
         n_ff[0] <= lead;
         f_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < 24; i++) begin : g_sq
      logic [63:0] sq;
      logic [32:0] t;
      assign sq = 64'(m_ff[i]) * 64'(m_ff[i]);
      assign t  = sq[63:31];
      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[i+1] <= t[32] ? t[32:1] : t[31:0];
            f_ff[i+1] <= {f_ff[i][22:0], t[32]};
            n_ff[i+1] <= n_ff[i];
         end
      end
   end

   assign lx = {n_ff[24], f_ff[24]};

endmodule

// ===== design/pld_div.sv =====
// Pipelined restoring divider for the scaled exponent, q = (a * 8192 + d / 2) / d,
// one quotient bit per stage. Depends on pld_pkg.
module pld_div import pld_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [27:0] a,
   input  logic [15:0] d,
   output logic [28:0] q
);

   logic [41:0] num;
   logic [15:0] rem_ff [0:29];
   logic [28:0] low_ff [0:29];
   logic [28:0] q_ff   [0:29];

   assign num = {1'b0, a, 13'd0} + 42'(d >> 1);

   // The quotient stays below 2^29, so the top bits alone are already below d.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= {3'd0, num[41:29]};
         low_ff[0] <= num[28:0];
         q_ff[0]   <= '0;
      end
   end

   for (genvar j = 0; j < 29; j++) begin : g_bit
      logic [16:0] r;
      logic [16:0] diff;
      logic        ge;
      assign r    = {rem_ff[j], low_ff[j][28]};
      assign diff = r - {1'b0, d};
      assign ge   = r >= {1'b0, d};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1] <= ge ? diff[15:0] : r[15:0];
            low_ff[j+1] <= {low_ff[j][27:0], 1'b0};
            q_ff[j+1]   <= {q_ff[j][27:0], ge};
         end
      end
   end

   assign q = q_ff[29];

endmodule

// ===== design/pld_pow.sv =====
// Pipelined power of two 2^-q from a table of square-root constants, then scaling to
// full range with rounding and clamping. Depends on pld_pkg.
module pld_pow import pld_pkg::*; #(
   parameter int unsigned CHANNEL_BITS = 16
) (
   input  logic        clock,
   input  logic        en,
   input  logic [28:0] q,
   output logic [15:0] y
);

   localparam logic [15:0] ChMax = 16'((32'd1 << CHANNEL_BITS) - 32'd1);

   logic [32:0] p_ff [0:23];
   logic [28:0] q_ff [0:23];
   logic [48:0] prod_ff;
   logic [5:0]  s_ff;
   logic [49:0] rounded;
   logic [49:0] shifted;

   for (genvar k = 0; k < 24; k++) begin : g_step
      localparam logic [31:0] Ck = pow_const(k + 1);
      logic [32:0] p_src;
      logic [28:0] q_src;
      logic [65:0] mul;
      if (k == 0) begin : g_first
         assign p_src = 33'h1_0000_0000;
         assign q_src = q;
      end else begin : g_next
         assign p_src = p_ff[k-1];
         assign q_src = q_ff[k-1];
      end
      assign mul = 66'(p_src) * 66'(Ck);
      always_ff @(posedge clock) begin
         if (en) begin
            p_ff[k] <= q_src[23-k] ? mul[64:32] : p_src;
            q_ff[k] <= q_src;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= 49'(ChMax) * 49'(p_ff[23]);
         s_ff    <= 6'd32 + {1'b0, q_ff[23][28:24]};
      end
   end

   always_comb begin
      rounded = {1'b0, prod_ff} + (50'd1 << (s_ff - 6'd1));
      shifted = rounded >> s_ff;
      y = (shifted[17:0] > 18'(ChMax)) ? ChMax : shifted[15:0];
   end

endmodule

// ===== design/pld_lane.sv =====
// One colour lane: saturation, bypass detection, log2, exponent divide and power.
// Depends on pld_pkg, pld_log2, pld_div and pld_pow.
module pld_lane import pld_pkg::*; #(
   parameter int unsigned CHANNEL_BITS = 16
) (
   input  logic                clock,
   input  logic                en,
   input  logic [15:0]         x,
   input  logic [EXP_BITS-1:0] exposure,
   output logic [15:0]         y
);

   localparam logic [15:0] ChMax  = 16'((32'd1 << CHANNEL_BITS) - 32'd1);
   localparam logic [27:0] LogMax = log2_q24(ChMax);

   logic [15:0] xs;
   logic        byp;
   logic [27:0] lx;
   logic [27:0] a_ff;
   logic [28:0] q;
   logic [15:0] yp;
   logic        byp_ff [0:LANE_LAT-1];
   logic [15:0] x_ff   [0:LANE_LAT-1];

   assign xs  = (x > ChMax) ? ChMax : x;
   // Black, full scale and zero exposure all leave the sample as it is.
   assign byp = (xs == '0) || (xs == ChMax) || (exposure == '0);

   pld_log2 u_log2 (.clock(clock), .en(en), .v(xs), .lx(lx));

   always_ff @(posedge clock) begin
      if (en) a_ff <= (LogMax > lx) ? (LogMax - lx) : '0;
   end

   pld_div u_div (.clock(clock), .en(en), .a(a_ff), .d(EXP_ONE + 16'(exposure)), .q(q));

   pld_pow #(.CHANNEL_BITS(CHANNEL_BITS)) u_pow (.clock(clock), .en(en), .q(q), .y(yp));

   always_ff @(posedge clock) begin
      if (en) begin
         byp_ff[0] <= byp;
         x_ff[0]   <= xs;
         for (int i = 1; i < LANE_LAT; i++) begin
            byp_ff[i] <= byp_ff[i-1];
            x_ff[i]   <= x_ff[i-1];
         end
      end
   end

   assign y = byp_ff[LANE_LAT-1] ? x_ff[LANE_LAT-1] : yp;

endmodule

// ===== design/rgb_power_law_midtone_dodge.sv =====
// Power-law midtone dodge for RGBA pixels: each colour channel is raised to the
// power 1 / (1 + exposure / 8192) on a normalized scale, alpha and the last-pixel mark pass.
// Depends on pld_pkg and pld_lane.
//
// Input beats arrive on req_valid / req_stall / req_data, results leave on
// rsp_valid / rsp_stall / rsp_data. A beat moves when valid is high and stall low.
// The exposure register is written through csr_valid / csr_ready / csr_data, with
// csr_ready always high; write it only while no pixel is in flight.
// Three identical colour lanes run side by side and the output register merges their
// results with alpha and the last-pixel mark.
// An accepted pixel passes to rsp_data through 25 stages of the log2 unit, one
// difference stage, 30 stages of the exponent divider, 25 stages of the power unit
// and the output register. Throughput is one pixel per cycle unless stalled.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// req_stall is raised; otherwise bubbles flow through freely.
// Synchronous reset clears the valid pipeline, the output valid and sets exposure to 0.
module rgb_power_law_midtone_dodge import pld_pkg::*; #(
   parameter int unsigned CHANNEL_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pix_in_type          req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pix_out_type         rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [EXP_BITS-1:0] csr_data
);

   localparam logic [15:0] ChMax = 16'((32'd1 << CHANNEL_BITS) - 32'd1);

   logic [EXP_BITS-1:0] exposure_ff;
   logic                adv;
   logic                accept;
   logic                vld_ff   [0:LANE_LAT-1];
   logic [15:0]         alpha_ff [0:LANE_LAT-1];
   logic                last_ff  [0:LANE_LAT-1];
   logic [15:0]         red_y;
   logic [15:0]         green_y;
   logic [15:0]         blue_y;
   logic                rsp_valid_ff;
   pix_out_type         rsp_data_ff;
   pix_out_type         rsp_data_in;

   assign csr_ready = 1'b1;
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign accept    = req_valid && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         exposure_ff <= '0;
      end else if (csr_valid) begin
         exposure_ff <= csr_data;
      end
   end

   pld_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_red (
      .clock(clock), .en(adv), .x(req_data.red_in), .exposure(exposure_ff), .y(red_y));
   pld_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_green (
      .clock(clock), .en(adv), .x(req_data.green_in), .exposure(exposure_ff), .y(green_y));
   pld_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_blue (
      .clock(clock), .en(adv), .x(req_data.blue_in), .exposure(exposure_ff), .y(blue_y));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANE_LAT; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= accept;
         for (int i = 1; i < LANE_LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         alpha_ff[0] <= req_data.alpha_in;
         last_ff[0]  <= req_data.last_pixel;
         for (int i = 1; i < LANE_LAT; i++) begin
            alpha_ff[i] <= alpha_ff[i-1];
            last_ff[i]  <= last_ff[i-1];
         end
      end
   end

   always_comb begin
      rsp_data_in.red_out        = red_y;
      rsp_data_in.green_out      = green_y;
      rsp_data_in.blue_out       = blue_y;
      rsp_data_in.alpha_out      = alpha_ff[LANE_LAT-1];
      rsp_data_in.last_pixel_out = last_ff[LANE_LAT-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[LANE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An accepted beat must enter the first valid stage.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> vld_ff[0])
      else $error("accepted pixel did not enter the pipeline");

   // Colour results never exceed full scale.
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.red_out <= ChMax && rsp_data.green_out <= ChMax
                     && rsp_data.blue_out <= ChMax))
      else $error("colour result above full scale");

   // A stalled result holds the whole pipeline, so the last valid stage keeps its value.
   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(vld_ff[LANE_LAT-1]))
      else $error("pipeline moved while the output was stalled");

endmodule

// ===== tb/sv/rgb_power_law_midtone_dodge_tb.sv =====
// Testbench for rgb_power_law_midtone_dodge: drives pixel beats, predicts each result
// with an integer power-law model and compares field by field. Depends on pld_pkg.
module rgb_power_law_midtone_dodge_tb import pld_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned CH_MAX = 64'd65535;
   localparam int unsigned RUN_LIMIT = 400000;
   localparam int unsigned DRAIN_CYCLES = 120;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   pix_in_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   pix_out_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [EXP_BITS-1:0] csr_data = '0;

   rgb_power_law_midtone_dodge u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   logic [EXP_BITS-1:0] cur_exposure = '0;
   longint unsigned dim_steps [0:24];
   pix_out_type expected_pixels [$];
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned errors = 0;
   int unsigned pixels_sent = 0;
   int unsigned pixels_checked = 0;
   int unsigned cycle_count = 0;

   function automatic longint unsigned int_sqrt(input longint unsigned v_arg);
      longint unsigned v, r, b;
      v = v_arg;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned log2_fixed(input longint unsigned v);
      int n;
      longint unsigned m, res;
      n = 0;
      while (n < 31 && (v >> (n + 1)) != 0) n++;
      m = v << (31 - n);
      res = longint'(n) << 24;
      for (int i = 23; i >= 0; i--) begin
         m = (m * m) >> 31;
         if (m >= (64'd1 << 32)) begin
            res = res | (64'd1 << i);
            m = m >> 1;
         end
      end
      return res;
   endfunction

   function automatic logic [15:0] dodge_channel(input logic [15:0] xin);
      longint unsigned x, a, lx, lm, d, q, p, s, y;
      x = xin;
      if (x == 0 || x == CH_MAX || cur_exposure == 0) return xin;
      lx = log2_fixed(x);
      lm = log2_fixed(CH_MAX);
      a = (lm > lx) ? lm - lx : 0;
      d = 8192 + cur_exposure;
      q = (a * 8192 + d / 2) / d;
      p = 64'd1 << 32;
      for (int k = 1; k <= 24; k++)
         if ((q >> (24 - k)) & 1) p = (p * dim_steps[k]) >> 32;
      s = 32 + (q >> 24);
      if (s >= 63) return '0;
      y = (CH_MAX * p + (64'd1 << (s - 1))) >> s;
      if (y > CH_MAX) y = CH_MAX;
      return y[15:0];
   endfunction

   function automatic pix_out_type dodge_pixel(input pix_in_type px);
      pix_out_type r;
      r.red_out = dodge_channel(px.red_in);
      r.green_out = dodge_channel(px.green_in);
      r.blue_out = dodge_channel(px.blue_in);
      r.alpha_out = px.alpha_in;
      r.last_pixel_out = px.last_pixel;
      return r;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("rgb_power_law_midtone_dodge_tb NOT OK");
         $finish;
      end
   end

   // Receiver: random stall, check every accepted result beat.
   always @(posedge clock) begin
      pix_out_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("result beat with no expected pixel");
               errors++;
            end else begin
               e = expected_pixels.pop_front();
               pixels_checked++;
               if (rsp_data.red_out !== e.red_out) begin
                  $error("red_out exp %0d got %0d", e.red_out, rsp_data.red_out); errors++;
               end
               if (rsp_data.green_out !== e.green_out) begin
                  $error("green_out exp %0d got %0d", e.green_out, rsp_data.green_out);
                  errors++;
               end
               if (rsp_data.blue_out !== e.blue_out) begin
                  $error("blue_out exp %0d got %0d", e.blue_out, rsp_data.blue_out); errors++;
               end
               if (rsp_data.alpha_out !== e.alpha_out) begin
                  $error("alpha_out exp %0d got %0d", e.alpha_out, rsp_data.alpha_out);
                  errors++;
               end
               if (rsp_data.last_pixel_out !== e.last_pixel_out) begin
                  $error("last_pixel_out exp %0d got %0d", e.last_pixel_out,
                         rsp_data.last_pixel_out);
                  errors++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Valid stays high between back-to-back beats, low while the sender idles or drains.
   task automatic send_pixel(input pix_in_type px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= px;
      expected_pixels.push_back(dodge_pixel(px));
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_exposure(input logic [EXP_BITS-1:0] v);
      drain_pipeline();
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_exposure = v;
   endtask

   function automatic pix_in_type rand_pixel();
      pix_in_type px;
      px.red_in = 16'($urandom);
      px.green_in = 16'($urandom);
      px.blue_in = 16'($urandom);
      px.alpha_in = 16'($urandom);
      px.last_pixel = 1'($urandom_range(1));
      // Bias some channels to the extremes and the dark end.
      case ($urandom_range(7))
         0: px.red_in = 16'h0000;
         1: px.green_in = 16'hFFFF;
         2: px.blue_in = 16'($urandom_range(15));
         3: px.red_in = 16'hFFFF - 16'($urandom_range(3));
         default: ;
      endcase
      return px;
   endfunction

   task automatic test_directed();
      logic [15:0] edge_vals [8] = '{16'h0000, 16'h0001, 16'h0002, 16'h00FF, 16'h8000,
                                    16'h7FFF, 16'hFFFE, 16'hFFFF};
      write_exposure(15'd0);
      for (int i = 0; i < 8; i++)
         send_pixel('{edge_vals[i], edge_vals[7 - i], edge_vals[(i + 3) % 8],
                      edge_vals[i], i[0]});
      write_exposure(15'h7FFF);
      for (int i = 0; i < 8; i++)
         send_pixel('{edge_vals[i], edge_vals[7 - i], edge_vals[(i + 5) % 8],
                      ~edge_vals[i], ~i[0]});
      write_exposure(15'd8192);
      for (int i = 0; i < 6; i++)
         send_pixel('{edge_vals[i + 1], edge_vals[i], edge_vals[7 - i], 16'hA5A5, 1'b1});
   endtask

   task automatic test_random(input int unsigned sidle, input int unsigned ridle,
                              input int unsigned count);
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      for (int i = 0; i < count; i++) begin
         if (i % 70 == 0) begin
            case ($urandom_range(3))
               0: write_exposure(15'd1);
               1: write_exposure(15'h7FFF);
               default: write_exposure(15'($urandom));
            endcase
         end
         send_pixel(rand_pixel());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(19, 54, 280);
      test_random(54, 19, 280);
      test_random(0, 0, 280);
      drain_pipeline();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d pixels, checked %0d results across several exposure settings,",
               pixels_sent, pixels_checked);
      $display("with random sender and receiver idling and without.");
      if (errors == 0 && expected_pixels.size() == 0)
         $display("rgb_power_law_midtone_dodge_tb OK");
      else
         $display("rgb_power_law_midtone_dodge_tb NOT OK");
      $finish;
   end

   initial begin
      dim_steps[0] = 64'd1 << 31;
      for (int k = 1; k <= 24; k++) dim_steps[k] = int_sqrt(dim_steps[k - 1] << 32);
   end
endmodule

// ===== sim.f =====
design/pld_pkg.sv
design/pld_log2.sv
design/pld_div.sv
design/pld_pow.sv
design/pld_lane.sv
design/rgb_power_law_midtone_dodge.sv
tb/sv/rgb_power_law_midtone_dodge_tb.sv
